FILE: sv/percussion_decay_sine_voice_top_defines.svh
// Assertion macros for the percussion voice checker.
// Depends on nothing; included by the checker file only.
`ifndef PERCUSSION_DECAY_SINE_VOICE_TOP_DEFINES_SVH
`define PERCUSSION_DECAY_SINE_VOICE_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PDSV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PDSV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pdsv_pkg.sv
// Shared types, constants and the quarter-wave sine function of the percussion voice.
// No dependencies; used by the top level and the sine table.
package pdsv_pkg;

    localparam int unsigned SINE_TABLE_BITS_DEF = 10;

    localparam int unsigned PHASE_W = 32;
    localparam int unsigned ENV_W   = 24;
    localparam int unsigned MAG_W   = 15;
    localparam int unsigned AUDIO_W = 16;
    localparam int unsigned PROD_W  = 2 * ENV_W;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR = 1'b1;

    localparam logic [PHASE_W-1:0] PHASE_STEP_RST   = 32'd97391549;
    localparam logic [ENV_W-1:0]   DECAY_FACTOR_RST = 24'd16775464;
    localparam logic [ENV_W-1:0]   ENV_FULL         = 24'hFFFFFF;

    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] MAG_MAX     = 64'd32767;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_ENV,
        S_ENV_WB,
        S_MUL_AUD,
        S_OUT
    } t_state;

    // quarter-wave entry k of a table with 2^tbits entries, Q0.15 magnitude
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k,
                                                      input int unsigned tbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] r;
        x  = (64'(k) * HALF_PI_Q30 + (64'd1 << (tbits - 3))) >> (tbits - 2);
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        p  = ((x2 * t) >> 30) / 110;
        t  = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p  = ((x2 * t) >> 30) / 72;
        t  = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p  = ((x2 * t) >> 30) / 42;
        t  = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p  = ((x2 * t) >> 30) / 20;
        t  = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p  = ((x2 * t) >> 30) / 6;
        t  = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        s  = (x * t) >> 30;
        r  = (s * MAG_MAX + (ONE_Q30 >> 1)) >> 30;
        if (r > MAG_MAX) begin
            r = MAG_MAX;
        end
        return r[MAG_W-1:0];
    endfunction

endpackage

FILE: sv/percussion_decay_sine_voice_top.sv
// Percussion voice: DDS sine oscillator with exponential decay envelope.
// Depends on pdsv_pkg and pdsv_sine_rom.
//
// One input beat is one sample tick carrying the active-low button level; each
// beat yields one output beat (audio sample and envelope). A beat is taken in the
// idle state and passes S_MUL_ENV, S_ENV_WB and S_MUL_AUD to S_OUT, where its
// result is loaded into the output register; the input is stalled in every state
// but idle: one 24x24 multiplier is used twice per sample (envelope times
// decay, then envelope times sine magnitude) with a registered sine table read
// in between. A new beat is taken while an earlier result still waits at the
// output; the next result waits in its last step until the output register is
// free. The sine table is built at elaboration, 2^(SINE_TABLE_BITS-2)+1 entries.
module percussion_decay_sine_voice_top #(
    parameter int unsigned SINE_TABLE_BITS = pdsv_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pdsv_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pdsv_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_button_level,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [pdsv_pkg::AUDIO_W-1:0] o_audio_sample,
    output logic [pdsv_pkg::ENV_W-1:0]          o_envelope_level
);

    typedef struct packed {
        logic accept;
        logic mul_en;
        logic mul_aud;
        logic env_wb;
        logic out_load;
    } t_ctl;

    pdsv_pkg::t_state r_state;
    pdsv_pkg::t_state n_state;
    t_ctl             w_ctl;

    logic [pdsv_pkg::PHASE_W-1:0] r_phase_step;
    logic [pdsv_pkg::ENV_W-1:0]   r_decay;
    logic                         r_prev_btn;
    logic [pdsv_pkg::ENV_W-1:0]   r_env;
    logic [pdsv_pkg::PHASE_W-1:0] r_phase;
    logic [pdsv_pkg::PROD_W-1:0]  r_prod;
    logic                         r_out_valid;
    logic [pdsv_pkg::AUDIO_W-1:0] r_audio;
    logic [pdsv_pkg::ENV_W-1:0]   r_env_out;

    logic [pdsv_pkg::MAG_W-1:0]   w_mag;
    logic                         w_neg;
    logic [pdsv_pkg::ENV_W-1:0]   w_mul_b;
    logic [pdsv_pkg::PROD_W-1:0]  w_prod;
    logic [pdsv_pkg::AUDIO_W-1:0] w_aud_mag;
    logic [pdsv_pkg::AUDIO_W-1:0] w_audio;
    logic [pdsv_pkg::ENV_W-1:0]   w_env_start;

    pdsv_sine_rom #(
        .TBITS (SINE_TABLE_BITS)
    ) u_sine (
        .i_clk  (i_clk),
        .i_addr (r_phase[pdsv_pkg::PHASE_W-1 -: SINE_TABLE_BITS]),
        .o_mag  (w_mag),
        .o_neg  (w_neg)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pdsv_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = pdsv_pkg::S_MUL_ENV;
                end
            end
            pdsv_pkg::S_MUL_ENV: n_state = pdsv_pkg::S_ENV_WB;
            pdsv_pkg::S_ENV_WB:  n_state = pdsv_pkg::S_MUL_AUD;
            pdsv_pkg::S_MUL_AUD: n_state = pdsv_pkg::S_OUT;
            pdsv_pkg::S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = pdsv_pkg::S_IDLE;
                end
            end
            default: n_state = pdsv_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_ctl = '0;
        unique case (r_state)
            pdsv_pkg::S_IDLE:    w_ctl.accept = i_in_valid;
            pdsv_pkg::S_MUL_ENV: w_ctl.mul_en = 1'b1;
            pdsv_pkg::S_ENV_WB:  w_ctl.env_wb = 1'b1;
            pdsv_pkg::S_MUL_AUD: begin
                w_ctl.mul_en  = 1'b1;
                w_ctl.mul_aud = 1'b1;
            end
            pdsv_pkg::S_OUT:     w_ctl.out_load = !r_out_valid || !i_out_stall;
            default:             w_ctl = '0;
        endcase
    end

    assign o_in_stall = (r_state != pdsv_pkg::S_IDLE);

    // shared multiplier
    assign w_mul_b = w_ctl.mul_aud ? pdsv_pkg::ENV_W'(w_mag) : r_decay;
    assign w_prod  = pdsv_pkg::PROD_W'(r_env) * pdsv_pkg::PROD_W'(w_mul_b);

    assign w_env_start = (!i_button_level && r_prev_btn) ? pdsv_pkg::ENV_FULL : r_env;
    assign w_aud_mag   = {1'b0, r_prod[pdsv_pkg::ENV_W +: pdsv_pkg::MAG_W]};
    assign w_audio     = w_neg ? (pdsv_pkg::AUDIO_W'(0) - w_aud_mag) : w_aud_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pdsv_pkg::S_IDLE;
            r_phase_step <= pdsv_pkg::PHASE_STEP_RST;
            r_decay      <= pdsv_pkg::DECAY_FACTOR_RST;
            r_prev_btn   <= 1'b1;
            r_env        <= pdsv_pkg::ENV_FULL;
            r_phase      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pdsv_pkg::REG_PHASE_STEP:   r_phase_step <= i_cfg_data;
                    pdsv_pkg::REG_DECAY_FACTOR: r_decay <= i_cfg_data[pdsv_pkg::ENV_W-1:0];
                    default: ;
                endcase
            end
            if (w_ctl.accept) begin
                r_prev_btn <= i_button_level;
                r_env      <= w_env_start;
                r_phase    <= r_phase + r_phase_step;
            end else if (w_ctl.env_wb) begin
                r_env <= r_prod[pdsv_pkg::ENV_W +: pdsv_pkg::ENV_W];
            end
            if (w_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.mul_en) begin
            r_prod <= w_prod;
        end
        if (w_ctl.out_load) begin
            r_audio   <= w_audio;
            r_env_out <= r_env;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_audio_sample   = r_audio;
    assign o_envelope_level = r_env_out;

endmodule

FILE: sv/pdsv_sine_rom.sv
// Full-turn sine lookup from a constant quarter-wave table, registered read.
// Depends on pdsv_pkg (quarter_sine, widths).
module pdsv_sine_rom #(
    parameter int unsigned TBITS = pdsv_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic [TBITS-1:0]           i_addr,
    output logic [pdsv_pkg::MAG_W-1:0] o_mag,
    output logic                       o_neg
);

    localparam int unsigned QUARTER = 1 << (TBITS - 2);

    logic [pdsv_pkg::MAG_W-1:0] w_qtab [QUARTER+1];
    logic [1:0]                 w_quad;
    logic [TBITS-3:0]           w_rem;
    logic [TBITS-2:0]           w_sel;
    logic [pdsv_pkg::MAG_W-1:0] r_mag;
    logic                       r_neg;

    for (genvar gk = 0; gk <= QUARTER; gk++) begin : g_qtab
        localparam logic [pdsv_pkg::MAG_W-1:0] QV = pdsv_pkg::quarter_sine(gk, TBITS);
        assign w_qtab[gk] = QV;
    end

    assign w_quad = i_addr[TBITS-1:TBITS-2];
    assign w_rem  = i_addr[TBITS-3:0];
    assign w_sel  = w_quad[0] ? ((TBITS-1)'(QUARTER) - {1'b0, w_rem}) : {1'b0, w_rem};

    always_ff @(posedge i_clk) begin
        r_mag <= w_qtab[w_sel];
        r_neg <= w_quad[1];
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg;

endmodule

FILE: sv/pdsv_checker.sv
// Port-level checker for the percussion voice, bound to the top level.
// Depends on pdsv_pkg and percussion_decay_sine_voice_top_defines.svh.
`include "percussion_decay_sine_voice_top_defines.svh"

module pdsv_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_stall,
    input logic                                i_out_valid,
    input logic                                i_out_stall,
    input logic signed [pdsv_pkg::AUDIO_W-1:0] i_audio_sample,
    input logic [pdsv_pkg::ENV_W-1:0]          i_envelope_level
);

    logic w_in_beat;

    assign w_in_beat = i_in_valid && !i_in_stall;

    `PDSV_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, w_in_beat, i_in_stall,
        "not busy after input beat")
    `PDSV_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, w_in_beat, !$rose(i_out_valid),
        "result one cycle after beat")
    `PDSV_ASSERT_NOW(a_result_from_work, i_clk, i_rst_n, $rose(i_out_valid), $past(i_in_stall),
        "result without work")
    `PDSV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall,
        i_out_valid && $stable(i_audio_sample) && $stable(i_envelope_level),
        "stalled output beat changed")

endmodule

bind percussion_decay_sine_voice_top pdsv_checker u_pdsv_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .i_in_stall       (o_in_stall),
    .i_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .i_audio_sample   (o_audio_sample),
    .i_envelope_level (o_envelope_level)
);
